[src/bqs_pkg.sv]
// Package for the busiest queue scheduler: request codes, result status codes,
// sequencer states and default sizes. No dependencies.
`default_nettype none

package bqs_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int ID_W        = 8;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_UPDATE = 2'd2,
        FN_SELECT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DUP     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_DONE  = 2'd3
    } state_t;

endpackage

`default_nettype wire

[src/bqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/busiest_queue_scheduler_top.sv]
// Busiest queue scheduler top level: request sequencer, slot table RAM and
// result register. Depends on bqs_pkg and bqs_ram.
//
// Usage:
//   Requests enter on s_* (valid/ready): add, remove or update a worker by
//   id, or select the next worker to run. Each request yields exactly one
//   result on m_* (valid/ready): status, chosen worker and table-empty flag.
//   Workers sit packed in insertion order in a single-port-read RAM.
//   Timing: one request at a time. The id or select scan reads one RAM
//   entry per cycle up to the hit or the last stored worker; a remove that
//   hits then closes the gap by moving each later entry down one slot, and
//   the result register is loaded last. s_ready is low while a request is
//   in work.
//   The result register decouples the sides: a new request is taken while a
//   result still waits; if the receiver stalls, the following request holds
//   in its final step until the result register is free.
//   Reset (aresetn low, synchronous) empties the table and drops any result.
`default_nettype none

module busiest_queue_scheduler_top #(
    parameter int MAX_WORKERS = bqs_pkg::MAX_WORKERS,
    parameter int COUNT_BITS  = bqs_pkg::COUNT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_worker_id,
    input  wire logic        s_is_blocked,
    input  wire logic [15:0] s_pending_msgs,
    input  wire logic [15:0] s_pending_internal,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_chosen_valid,
    output logic [7:0]       m_chosen_id,
    output logic             m_table_empty
);

    localparam int AW = $clog2(MAX_WORKERS);
    localparam int CW = $clog2(MAX_WORKERS + 1);
    localparam int CB = COUNT_BITS;
    localparam int IW = bqs_pkg::ID_W;
    localparam int EW = IW + 1 + 2 * CB;
    localparam logic [32:0] CNT_TOP = (33'd1 << COUNT_BITS) - 33'd1;

    bqs_pkg::state_t  state_reg, state_next;
    bqs_pkg::func_t   func_reg, func_next;
    logic [IW-1:0]    id_reg, id_next;
    logic             blk_reg, blk_next;
    logic [CB-1:0]    msgs_reg, msgs_next;
    logic [CB-1:0]    intl_reg, intl_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pidx_reg, pidx_next;
    logic             have_reg, have_next;
    logic [CB-1:0]    best_reg, best_next;
    logic [IW-1:0]    best_id_reg, best_id_next;
    bqs_pkg::status_t status_reg, status_next;
    logic             cvalid_reg, cvalid_next;
    logic [IW-1:0]    cid_reg, cid_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_cvalid_reg, m_cvalid_next;
    logic [IW-1:0]    m_cid_reg, m_cid_next;
    logic             m_empty_reg, m_empty_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;

    logic [IW-1:0]    r_id;
    logic             r_blk;
    logic [CB-1:0]    r_msgs;
    logic [CB-1:0]    r_intl;
    logic [32:0]      msgs_wide;
    logic [32:0]      intl_wide;
    logic [CB-1:0]    msgs_sat;
    logic [CB-1:0]    intl_sat;
    logic             hit;
    logic             scan_end;
    logic             out_free;

    bqs_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_WORKERS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign r_id   = ram_rdata[EW-1 -: IW];
    assign r_blk  = ram_rdata[2*CB];
    assign r_msgs = ram_rdata[2*CB-1 -: CB];
    assign r_intl = ram_rdata[CB-1:0];

    // saturate incoming counts to the stored width
    assign msgs_wide = 33'(s_pending_msgs);
    assign intl_wide = 33'(s_pending_internal);
    assign msgs_sat  = (msgs_wide > CNT_TOP) ? CNT_TOP[CB-1:0] : msgs_wide[CB-1:0];
    assign intl_sat  = (intl_wide > CNT_TOP) ? CNT_TOP[CB-1:0] : intl_wide[CB-1:0];

    assign hit = pend_reg && ((func_reg == bqs_pkg::FN_SELECT)
                              ? (r_blk && (r_intl != '0))
                              : (r_id == id_reg));
    assign scan_end = !pend_reg && (issue_reg >= used_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == bqs_pkg::S_IDLE);

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        id_next       = id_reg;
        blk_next      = blk_reg;
        msgs_next     = msgs_reg;
        intl_next     = intl_reg;
        used_next     = used_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        have_next     = have_reg;
        best_next     = best_reg;
        best_id_next  = best_id_reg;
        status_next   = status_reg;
        cvalid_next   = cvalid_reg;
        cid_next      = cid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_cvalid_next = m_cvalid_reg;
        m_cid_next    = m_cid_reg;
        m_empty_next  = m_empty_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = issue_reg[AW-1:0];

        case (state_reg)
            bqs_pkg::S_IDLE: begin
                if (s_valid) begin
                    func_next    = bqs_pkg::func_t'(s_func);
                    id_next      = s_worker_id;
                    blk_next     = s_is_blocked;
                    msgs_next    = msgs_sat;
                    intl_next    = intl_sat;
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    have_next    = 1'b0;
                    best_next    = '0;
                    best_id_next = '0;
                    status_next  = bqs_pkg::STAT_OK;
                    cvalid_next  = 1'b0;
                    cid_next     = '0;
                    state_next   = bqs_pkg::S_SCAN;
                end
            end
            bqs_pkg::S_SCAN: begin
                if (issue_reg < used_reg) begin
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && !hit && (func_reg == bqs_pkg::FN_SELECT) && !r_blk
                    && (r_msgs != '0) && (!have_reg || (r_msgs > best_reg))) begin
                    have_next    = 1'b1;
                    best_next    = r_msgs;
                    best_id_next = r_id;
                end
                if (hit) begin
                    pend_next  = 1'b0;
                    state_next = bqs_pkg::S_DONE;
                    case (func_reg)
                        bqs_pkg::FN_ADD: begin
                            status_next = bqs_pkg::STAT_DUP;
                        end
                        bqs_pkg::FN_REMOVE: begin
                            issue_next = CW'(pidx_reg) + CW'(1);
                            state_next = bqs_pkg::S_SHIFT;
                        end
                        bqs_pkg::FN_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_reg;
                            ram_wdata = {id_reg, blk_reg, msgs_reg, intl_reg};
                        end
                        default: begin
                            cvalid_next = 1'b1;
                            cid_next    = r_id;
                        end
                    endcase
                end else if (scan_end) begin
                    state_next = bqs_pkg::S_DONE;
                    case (func_reg)
                        bqs_pkg::FN_ADD: begin
                            if (used_reg == CW'(MAX_WORKERS)) begin
                                status_next = bqs_pkg::STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = used_reg[AW-1:0];
                                ram_wdata = {id_reg, blk_reg, msgs_reg, intl_reg};
                                used_next = used_reg + CW'(1);
                            end
                        end
                        bqs_pkg::FN_REMOVE, bqs_pkg::FN_UPDATE: begin
                            status_next = bqs_pkg::STAT_MISSING;
                        end
                        default: begin
                            cvalid_next = have_reg;
                            cid_next    = best_id_reg;
                        end
                    endcase
                end
            end
            bqs_pkg::S_SHIFT: begin
                // close the gap: entry i+1 is read, and written to i in the next cycle
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (issue_reg < used_reg) begin
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        used_next  = used_reg - CW'(1);
                        state_next = bqs_pkg::S_DONE;
                    end
                end
            end
            bqs_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_cvalid_next = cvalid_reg;
                    m_cid_next    = cid_reg;
                    m_empty_next  = (used_reg == '0);
                    state_next    = bqs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bqs_pkg::S_IDLE;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        blk_reg      <= blk_next;
        msgs_reg     <= msgs_next;
        intl_reg     <= intl_next;
        issue_reg    <= issue_next;
        pidx_reg     <= pidx_next;
        have_reg     <= have_next;
        best_reg     <= best_next;
        best_id_reg  <= best_id_next;
        status_reg   <= status_next;
        cvalid_reg   <= cvalid_next;
        cid_reg      <= cid_next;
        m_status_reg <= m_status_next;
        m_cvalid_reg <= m_cvalid_next;
        m_cid_reg    <= m_cid_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_chosen_valid = m_cvalid_reg;
    assign m_chosen_id    = m_cid_reg;
    assign m_table_empty  = m_empty_reg;

endmodule

`default_nettype wire

[src/bqs_checker.sv]
// Port-level checker for the busiest queue scheduler, bound to the top level.
// Depends on bqs_pkg and busiest_queue_scheduler_top.
`default_nettype none

module bqs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic        m_chosen_valid,
    input wire logic [7:0]  m_chosen_id,
    input wire logic        m_table_empty
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_chosen_valid) && $stable(m_chosen_id) && $stable(m_table_empty))
        else $error("result changed while stalled");

    // one request in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_chosen_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chosen_valid |-> (m_status == bqs_pkg::STAT_OK) && !m_table_empty)
        else $error("chosen worker with bad status or empty table");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chosen_valid |-> (m_chosen_id == 8'd0))
        else $error("nonzero id without a choice");

    a_dup_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == bqs_pkg::STAT_DUP) || (m_status == bqs_pkg::STAT_FULL))
            |-> !m_table_empty)
        else $error("duplicate or full reported on empty table");

endmodule

bind busiest_queue_scheduler_top bqs_checker u_bqs_checker (.*);

`default_nettype wire

[dv/busiest_queue_scheduler_top_tb.sv]
// Self-checking testbench for busiest_queue_scheduler_top: a directed table of requests,
// then random add/remove/update/select traffic checked against a worker roster model.
// Depends on bqs_pkg and the RTL under src.
`timescale 1ns / 1ps

module busiest_queue_scheduler_top_tb;
    import bqs_pkg::*;

    localparam int RANDOM_ITEMS = 1725;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_AFTER  = 600;
    localparam int STALL_CYCLES = 400;
    localparam int PAUSE_AT     = 900;
    localparam int CALM_FROM    = 1200;
    localparam int CALM_TO      = 1500;

    typedef struct {
        func_t       func;
        logic [7:0]  id;
        logic        blocked;
        logic [15:0] msgs;
        logic [15:0] intl;
    } request_t;

    typedef struct {
        status_t    status;
        logic       chosen_valid;
        logic [7:0] chosen_id;
        logic       table_empty;
    } outcome_t;

    typedef struct {
        request_t rq;
        bit       typed;
        outcome_t want;
    } directed_row_t;

    typedef struct {
        logic [7:0]  id;
        logic        blocked;
        logic [15:0] msgs;
        logic [15:0] intl;
    } roster_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FN_SELECT;
    logic [7:0]  s_worker_id = 8'h00;
    logic        s_is_blocked = 1'b0;
    logic [15:0] s_pending_msgs = 16'h0000;
    logic [15:0] s_pending_internal = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_chosen_valid;
    logic [7:0]  m_chosen_id;
    logic        m_table_empty;

    roster_entry_t roster[$];
    outcome_t      pending_outcomes[$];
    int            error_count = 0;
    int            outcomes_seen = 0;
    int            cycle_count = 0;
    bit            calm_span = 1'b0;

    directed_row_t directed_rows [25] = '{
        '{'{FN_SELECT, 8'h00, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b1}},
        '{'{FN_REMOVE, 8'h05, 1'b0, 16'h0000, 16'h0000}, 1'b1,
          '{STAT_MISSING, 1'b0, 8'h00, 1'b1}},
        '{'{FN_UPDATE, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{STAT_MISSING, 1'b0, 8'h00, 1'b1}},
        '{'{FN_ADD, 8'h00, 1'b0, 16'h0000, 16'hFFFF}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'hFF, 1'b1, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h80, 1'b0, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h7F, 1'b0, 16'hFFFF, 16'hFFFF}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h01, 1'b0, 16'h0001, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h55, 1'b1, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'hAA, 1'b1, 16'h0000, 16'h0001}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h10, 1'b0, 16'h1234, 16'h5678}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h20, 1'b0, 16'h00FF, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h30, 1'b1, 16'h8000, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h40, 1'b0, 16'h7FFF, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h50, 1'b0, 16'hFFFE, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h60, 1'b0, 16'h0002, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h70, 1'b1, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h0F, 1'b0, 16'h00F0, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'hF0, 1'b0, 16'h0F0F, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h33, 1'b0, 16'h0001, 16'h0001}, 1'b1, '{STAT_FULL, 1'b0, 8'h00, 1'b0}},
        '{'{FN_ADD, 8'h80, 1'b0, 16'h0001, 16'h0001}, 1'b1, '{STAT_DUP, 1'b0, 8'h00, 1'b0}},
        '{'{FN_SELECT, 8'h00, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_UPDATE, 8'hAA, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_REMOVE, 8'h80, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 1'b0, 8'h00, 1'b0}},
        '{'{FN_SELECT, 8'h00, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{STAT_OK, 1'b0, 8'h00, 1'b0}}
    };

    busiest_queue_scheduler_top u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_worker_id        (s_worker_id),
        .s_is_blocked       (s_is_blocked),
        .s_pending_msgs     (s_pending_msgs),
        .s_pending_internal (s_pending_internal),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_chosen_valid     (m_chosen_valid),
        .m_chosen_id        (m_chosen_id),
        .m_table_empty      (m_table_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [15:0] saturate(logic [15:0] v);
        longint top;
        top = (longint'(1) << COUNT_BITS) - 1;
        if (longint'(v) > top) begin
            return 16'(top);
        end
        return v;
    endfunction

    // Applies one request to the roster and returns the result it should produce.
    function automatic outcome_t apply_request(request_t rq);
        outcome_t      oc;
        roster_entry_t w;
        int            hit;
        bit            have;
        logic [15:0]   best;
        oc = '{STAT_OK, 1'b0, 8'h00, 1'b0};
        hit = -1;
        have = 1'b0;
        best = 16'h0000;
        for (int i = 0; i < roster.size(); i++) begin
            if (roster[i].id == rq.id) begin
                hit = i;
                break;
            end
        end
        case (rq.func)
            FN_ADD: begin
                if (hit >= 0) begin
                    oc.status = STAT_DUP;
                end else if (roster.size() >= MAX_WORKERS) begin
                    oc.status = STAT_FULL;
                end else begin
                    w.id = rq.id;
                    w.blocked = rq.blocked;
                    w.msgs = saturate(rq.msgs);
                    w.intl = saturate(rq.intl);
                    roster.insert(roster.size(), w);
                end
            end
            FN_REMOVE: begin
                if (hit < 0) begin
                    oc.status = STAT_MISSING;
                end else begin
                    roster.delete(hit);
                end
            end
            FN_UPDATE: begin
                if (hit < 0) begin
                    oc.status = STAT_MISSING;
                end else begin
                    roster[hit].blocked = rq.blocked;
                    roster[hit].msgs = saturate(rq.msgs);
                    roster[hit].intl = saturate(rq.intl);
                end
            end
            default: begin
                for (int i = 0; i < roster.size(); i++) begin
                    if (roster[i].blocked) begin
                        if (roster[i].intl != 0) begin
                            oc.chosen_valid = 1'b1;
                            oc.chosen_id = roster[i].id;
                            break;
                        end
                    end else if (roster[i].msgs != 0 && (!have || roster[i].msgs > best)) begin
                        have = 1'b1;
                        best = roster[i].msgs;
                        oc.chosen_valid = 1'b1;
                        oc.chosen_id = roster[i].id;
                    end
                end
            end
        endcase
        oc.table_empty = (roster.size() == 0);
        return oc;
    endfunction

    function automatic request_t draw_request(bit growing);
        request_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < (growing ? 45 : 15)) begin
            rq.func = FN_ADD;
        end else if (pick < (growing ? 55 : 55)) begin
            rq.func = FN_REMOVE;
        end else if (pick < 75) begin
            rq.func = FN_UPDATE;
        end else begin
            rq.func = FN_SELECT;
        end
        pick = $urandom_range(0, 99);
        if (roster.size() != 0 && pick < (rq.func == FN_ADD ? 20 : 65)) begin
            rq.id = roster[$urandom_range(0, roster.size() - 1)].id;
        end else if (pick < 85) begin
            rq.id = 8'($urandom_range(0, 31));
        end else begin
            rq.id = 8'($urandom_range(0, 255));
        end
        rq.blocked = ($urandom_range(0, 99) < 30);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            rq.msgs = 16'h0000;
        end else if (pick < 25) begin
            rq.msgs = 16'hFFFF;
        end else if (pick < 55) begin
            rq.msgs = 16'($urandom_range(1, 7));
        end else begin
            rq.msgs = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            rq.intl = 16'h0000;
        end else if (pick < 60) begin
            rq.intl = 16'hFFFF;
        end else begin
            rq.intl = 16'($urandom);
        end
        return rq;
    endfunction

    task automatic offer_request(request_t rq, bit typed, outcome_t want);
        outcome_t predicted;
        while (!calm_span && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= rq.func;
        s_worker_id <= rq.id;
        s_is_blocked <= rq.blocked;
        s_pending_msgs <= rq.msgs;
        s_pending_internal <= rq.intl;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = apply_request(rq);
        pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", outcomes_seen, what, got, want);
        error_count++;
    endtask

    task automatic check_outcome();
        outcome_t exp;
        if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result, status", m_status, 0);
        end else begin
            exp = pending_outcomes.pop_front();
            if (m_status !== exp.status) begin
                report_mismatch("status", m_status, exp.status);
            end
            if (m_chosen_valid !== exp.chosen_valid) begin
                report_mismatch("chosen_valid", m_chosen_valid, exp.chosen_valid);
            end
            if (m_chosen_id !== exp.chosen_id) begin
                report_mismatch("chosen_id", m_chosen_id, exp.chosen_id);
            end
            if (m_table_empty !== exp.table_empty) begin
                report_mismatch("table_empty", m_table_empty, exp.table_empty);
            end
        end
        outcomes_seen++;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int  stall_left;
        bit  stall_done;
        bit  next_ready;
        stall_left = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_outcome();
            end
            if (!stall_done && outcomes_seen >= STALL_AFTER) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = calm_span || ($urandom_range(0, 99) >= 23);
            end
            m_ready <= next_ready;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        request_t rq;
        bit       growing;
        growing = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_outcomes.size() != 0) begin
                    @(posedge aclk);
                end
            end
            calm_span = (n >= CALM_FROM && n < CALM_TO);
            if (roster.size() >= MAX_WORKERS) begin
                growing = 1'b0;
            end else if (roster.size() <= 2) begin
                growing = 1'b1;
            end
            rq = draw_request(growing);
            offer_request(rq, 1'b0, '{STAT_OK, 1'b0, 8'h00, 1'b0});
        end
        calm_span = 1'b0;
        s_valid <= 1'b0;

        while (pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
src/bqs_pkg.sv
src/bqs_ram.sv
src/busiest_queue_scheduler_top.sv
src/bqs_checker.sv
dv/busiest_queue_scheduler_top_tb.sv
